[hw/rtl/qpe_pkg.sv]
// Shared constants, types and helpers for the quoted-printable encoder.
// No dependencies; imported by every module of the block.
package qpe_pkg;

    localparam int OUT_COUNT_WIDTH  = 16;
    localparam int LINE_COUNT_WIDTH = 12;
    localparam int ENC_LEN          = 3;

    localparam int CAP_LIMIT_W  = 16;
    localparam int LINE_LIMIT_W = 10;
    localparam int CAP_CMP_W    = (OUT_COUNT_WIDTH > CAP_LIMIT_W) ? OUT_COUNT_WIDTH : CAP_LIMIT_W;
    localparam int LINE_CMP_W   = (LINE_COUNT_WIDTH > LINE_LIMIT_W) ? LINE_COUNT_WIDTH
                                                                    : LINE_LIMIT_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WRAP_ON  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LINE_LEN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_CAP_ON = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN       = 2'd3;

    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_LOW  = 8'd33;
    localparam logic [7:0] CH_HIGH = 8'd126;

    typedef struct packed {
        logic                    line_wrap_on;
        logic [LINE_LIMIT_W-1:0] max_line_len;
        logic                    length_cap_on;
        logic [CAP_LIMIT_W-1:0]  max_len;
    } t_cfg;

    // One classified request on its way to the character sequencer
    typedef struct packed {
        logic [7:0] data;
        logic       marker;
        logic       enc;
        logic       brk;
        logic       stop;
        logic       last;
    } t_desc;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'd0, nib};
        end else begin
            ch = 8'h37 + {4'd0, nib};
        end
        return ch;
    endfunction

endpackage

[hw/rtl/qpe_front.sv]
// Front end: accepts requests, classifies each byte and keeps the text counters.
// Depends on qpe_pkg; pushes one descriptor per request into qpe_queue.
module qpe_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qpe_pkg::t_cfg  i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_text_end,
    input  logic           i_full,
    output logic           o_push,
    output qpe_pkg::t_desc o_desc
);
    import qpe_pkg::*;

    logic [OUT_COUNT_WIDTH-1:0]  r_out_count, n_out_count;
    logic [LINE_COUNT_WIDTH-1:0] r_line_count, n_line_count;
    logic                        r_stopped, n_stopped;

    logic                        accept;
    logic                        enc;
    logic                        stop;
    logic                        brk;
    logic [CAP_LIMIT_W-1:0]      cap_thr;
    logic [LINE_LIMIT_W-1:0]     line_thr;
    logic [OUT_COUNT_WIDTH:0]    oc_sum1, oc_sum2;
    logic [OUT_COUNT_WIDTH-1:0]  oc1, oc2;
    logic [LINE_COUNT_WIDTH:0]   lc_sum;
    logic [LINE_COUNT_WIDTH-1:0] lc_next;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        cap_thr  = (i_cfg.max_len >= CAP_LIMIT_W'(ENC_LEN))
                 ? i_cfg.max_len - CAP_LIMIT_W'(ENC_LEN) : '0;
        line_thr = (i_cfg.max_line_len >= LINE_LIMIT_W'(ENC_LEN))
                 ? i_cfg.max_line_len - LINE_LIMIT_W'(ENC_LEN) : '0;

        enc = (i_data_byte < CH_LOW) || (i_data_byte == CH_EQ) || (i_data_byte > CH_HIGH);

        oc_sum1 = {1'b0, r_out_count} + (enc ? (OUT_COUNT_WIDTH+1)'(ENC_LEN)
                                             : (OUT_COUNT_WIDTH+1)'(1));
        oc1     = oc_sum1[OUT_COUNT_WIDTH] ? '1 : oc_sum1[OUT_COUNT_WIDTH-1:0];

        stop = i_cfg.length_cap_on && (CAP_CMP_W'(oc1) >= CAP_CMP_W'(cap_thr));
        brk  = !stop && i_cfg.line_wrap_on
             && (LINE_CMP_W'(r_line_count) >= LINE_CMP_W'(line_thr));

        // soft break characters count towards the total
        oc_sum2 = {1'b0, oc1} + (OUT_COUNT_WIDTH+1)'(ENC_LEN);
        oc2     = oc_sum2[OUT_COUNT_WIDTH] ? '1 : oc_sum2[OUT_COUNT_WIDTH-1:0];

        lc_sum  = {1'b0, r_line_count} + (LINE_COUNT_WIDTH+1)'(ENC_LEN);
        lc_next = lc_sum[LINE_COUNT_WIDTH] ? '1 : lc_sum[LINE_COUNT_WIDTH-1:0];
    end

    always_comb begin
        o_push        = accept;
        o_desc.data   = i_data_byte;
        o_desc.marker = r_stopped;
        o_desc.enc    = enc;
        o_desc.brk    = !r_stopped && brk;
        o_desc.stop   = r_stopped || stop;
        o_desc.last   = i_text_end;

        n_out_count  = r_out_count;
        n_line_count = r_line_count;
        n_stopped    = r_stopped;
        if (accept) begin
            if (!r_stopped) begin
                n_stopped    = stop;
                n_out_count  = brk ? oc2 : oc1;
                n_line_count = brk ? LINE_COUNT_WIDTH'(ENC_LEN) : lc_next;
            end
            // clear for the next text
            if (i_text_end) begin
                n_out_count  = '0;
                n_line_count = '0;
                n_stopped    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_count  <= '0;
            r_line_count <= '0;
            r_stopped    <= 1'b0;
        end else begin
            r_out_count  <= n_out_count;
            r_line_count <= n_line_count;
            r_stopped    <= n_stopped;
        end
    end

endmodule

[hw/rtl/qpe_queue.sv]
// Short descriptor queue between the front end and the character sequencer.
// Depends on qpe_pkg for the descriptor type and depth.
module qpe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qpe_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output qpe_pkg::t_desc o_desc
);
    import qpe_pkg::*;

    t_desc                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;

    assign o_full  = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/qpe_back.sv]
// Back end: walks the queue head into the output register, one character per cycle unless stalled.
// Depends on qpe_pkg for the descriptor type, character codes and hex lookup.
module qpe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  qpe_pkg::t_desc i_q_desc,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_char,
    output logic           o_char_valid,
    output logic           o_run_last,
    output logic           o_encoded_end,
    output logic           o_was_stopped
);
    import qpe_pkg::*;

    logic [2:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_char_valid, r_run_last, r_encoded_end, r_was_stopped;

    logic [2:0] head_len;
    logic [2:0] n_chars;
    logic [2:0] brk_idx;
    logic       is_last;
    logic       load;
    logic [7:0] ch;

    always_comb begin
        head_len = i_q_desc.enc ? 3'(ENC_LEN) : 3'd1;
        n_chars  = i_q_desc.marker ? 3'd1 : head_len + (i_q_desc.brk ? 3'(ENC_LEN) : 3'd0);
        is_last  = (r_idx == n_chars - 3'd1);
        brk_idx  = r_idx - head_len;
        load     = i_q_valid && (!r_out_valid || i_out_ready);

        if (i_q_desc.marker) begin
            ch = 8'd0;
        end else if (r_idx < head_len) begin
            if (!i_q_desc.enc) begin
                ch = i_q_desc.data;
            end else begin
                case (r_idx)
                    3'd0:    ch = CH_EQ;
                    3'd1:    ch = hex_char(i_q_desc.data[7:4]);
                    default: ch = hex_char(i_q_desc.data[3:0]);
                endcase
            end
        end else begin
            case (brk_idx)
                3'd0:    ch = CH_EQ;
                3'd1:    ch = CH_CR;
                default: ch = CH_LF;
            endcase
        end
    end

    assign o_q_pop = load && is_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char    <= ch;
            r_char_valid  <= !i_q_desc.marker;
            r_run_last    <= is_last;
            r_encoded_end <= is_last && i_q_desc.last;
            r_was_stopped <= i_q_desc.stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= is_last ? 3'd0 : r_idx + 3'd1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_char_valid  = r_char_valid;
    assign o_run_last    = r_run_last;
    assign o_encoded_end = r_encoded_end;
    assign o_was_stopped = r_was_stopped;

endmodule

[hw/rtl/quoted_printable_encoder_core.sv]
// Quoted-printable encoder top level: configuration registers and the three stages.
// Depends on qpe_pkg, qpe_front, qpe_queue and qpe_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one byte of text per request,
//   with i_text_end on the final byte. Each request yields a run of one to six
//   output characters on the output channel (o_out_valid / i_out_ready); the
//   last character of a run carries o_run_last. A byte dropped after the length
//   cap gives one marker character with o_char_valid low.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes a
//   register by index; write only while no request is in flight.
//   An accepted request passes through the descriptor queue and then the output
//   register before its first character appears. The character sequencer drives
//   the single output register with one output character per cycle while the
//   receiver takes them. Requests are taken every cycle while the 4-deep descriptor
//   queue has room, also while a character waits for the receiver.
//   Reset clears counters, queue and output valid, and loads register defaults.
//   When the receiver stalls, the output holds and the queue fills, then
//   o_in_ready drops until space returns.
module quoted_printable_encoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [qpe_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [qpe_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_text_end,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_out_char,
    output logic                              o_char_valid,
    output logic                              o_run_last,
    output logic                              o_encoded_end,
    output logic                              o_was_stopped
);
    import qpe_pkg::*;

    t_cfg  r_cfg;
    logic  q_full, q_push, q_pop, q_valid;
    t_desc push_desc, head_desc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_wrap_on  <= 1'b0;
            r_cfg.max_line_len  <= LINE_LIMIT_W'(76);
            r_cfg.length_cap_on <= 1'b0;
            r_cfg.max_len       <= CAP_LIMIT_W'(65535);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LINE_WRAP_ON:  r_cfg.line_wrap_on  <= i_cfg_data[0];
                REG_MAX_LINE_LEN:  r_cfg.max_line_len  <= i_cfg_data[LINE_LIMIT_W-1:0];
                REG_LENGTH_CAP_ON: r_cfg.length_cap_on <= i_cfg_data[0];
                REG_MAX_LEN:       r_cfg.max_len       <= i_cfg_data[CAP_LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    qpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_text_end  (i_text_end),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_desc      (push_desc)
    );

    qpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (head_desc)
    );

    qpe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_desc      (head_desc),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_char    (o_out_char),
        .o_char_valid  (o_char_valid),
        .o_run_last    (o_run_last),
        .o_encoded_end (o_encoded_end),
        .o_was_stopped (o_was_stopped)
    );

endmodule

[test/quoted_printable_encoder_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for quoted_printable_encoder_core: directed and random texts,
// predicted character by character and checked on the output channel.
// Depends on qpe_pkg and the quoted_printable_encoder_core RTL.
module quoted_printable_encoder_core_tb;

    import qpe_pkg::*;

    localparam int unsigned OUT_TOP  = (1 << OUT_COUNT_WIDTH) - 1;
    localparam int unsigned LINE_TOP = (1 << LINE_COUNT_WIDTH) - 1;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       run_last;
        logic       encoded_end;
        logic       was_stopped;
    } qp_char_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [7:0]             i_data_byte;
    logic                   i_text_end;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [7:0]             o_out_char;
    logic                   o_char_valid;
    logic                   o_run_last;
    logic                   o_encoded_end;
    logic                   o_was_stopped;

    // Encoder state as the block should hold it
    t_cfg                        enc_cfg;
    logic [LINE_COUNT_WIDTH-1:0] enc_line_count;
    logic [OUT_COUNT_WIDTH-1:0]  enc_out_count;
    logic                        enc_stopped;

    qp_char_t pending_chars[$];
    int       error_count;
    bit       no_idle;
    int       stall_left;

    quoted_printable_encoder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_text_end    (i_text_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_char    (o_out_char),
        .o_char_valid  (o_char_valid),
        .o_run_last    (o_run_last),
        .o_encoded_end (o_encoded_end),
        .o_was_stopped (o_was_stopped)
    );

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic int unsigned sat_add(input int unsigned v, input int unsigned a,
                                            input int unsigned top);
        return (v + a > top) ? top : v + a;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return (nib > 4'd9) ? 8'h41 + nib - 8'd10 : 8'h30 + nib;
    endfunction

    function automatic qp_char_t plain_char(input logic [7:0] ch, input logic ok);
        return '{out_char: ch, char_valid: ok, run_last: 1'b0, encoded_end: 1'b0,
                 was_stopped: 1'b0};
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [7:0] picks[8];
        picks = '{8'h00, 8'hFF, 8'h20, 8'h21, 8'h7E, 8'h7F, 8'h3C, 8'h3E};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(33, 126));
            4, 5, 6:    return 8'($urandom_range(0, 255));
            7:          return CH_EQ;
            default:    return picks[$urandom_range(0, 7)];
        endcase
    endfunction

    // Work out the characters one accepted byte must produce and queue them
    function automatic void encode_byte(input logic [7:0] b, input logic last);
        qp_char_t    run[2*ENC_LEN];
        int          n;
        int unsigned cap_thr;
        int unsigned line_thr;
        logic        special;
        n = 0;
        if (enc_stopped) begin
            run[n++] = plain_char(8'h00, 1'b0);
        end else begin
            cap_thr  = (enc_cfg.max_len >= ENC_LEN) ? enc_cfg.max_len - ENC_LEN : 0;
            line_thr = (enc_cfg.max_line_len >= ENC_LEN) ? enc_cfg.max_line_len - ENC_LEN : 0;
            special  = (b < CH_LOW) || (b == CH_EQ) || (b > CH_HIGH);
            if (special) begin
                run[n++] = plain_char(CH_EQ, 1'b1);
                run[n++] = plain_char(hex_ascii(b[7:4]), 1'b1);
                run[n++] = plain_char(hex_ascii(b[3:0]), 1'b1);
                enc_out_count = OUT_COUNT_WIDTH'(sat_add(enc_out_count, 3, OUT_TOP));
            end else begin
                run[n++] = plain_char(b, 1'b1);
                enc_out_count = OUT_COUNT_WIDTH'(sat_add(enc_out_count, 1, OUT_TOP));
            end
            // the cap takes precedence: no soft break after the stopping byte
            if (enc_cfg.length_cap_on && enc_out_count >= cap_thr) begin
                enc_stopped = 1'b1;
            end else if (enc_cfg.line_wrap_on && enc_line_count >= line_thr) begin
                run[n++] = plain_char(CH_EQ, 1'b1);
                run[n++] = plain_char(CH_CR, 1'b1);
                run[n++] = plain_char(CH_LF, 1'b1);
                enc_out_count  = OUT_COUNT_WIDTH'(sat_add(enc_out_count, 3, OUT_TOP));
                enc_line_count = LINE_COUNT_WIDTH'(ENC_LEN);
            end else begin
                enc_line_count = LINE_COUNT_WIDTH'(sat_add(enc_line_count, ENC_LEN,
                                                           LINE_TOP));
            end
        end
        for (int k = 0; k < n; k++) run[k].was_stopped = enc_stopped;
        run[n-1].run_last    = 1'b1;
        run[n-1].encoded_end = last;
        for (int k = 0; k < n; k++) pending_chars.insert(pending_chars.size(), run[k]);
        if (last) begin
            enc_line_count = '0;
            enc_out_count  = '0;
            enc_stopped    = 1'b0;
        end
    endfunction

    // Output side: random back-pressure and comparison with the oldest expectation
    always @(posedge i_clk) begin : out_monitor
        qp_char_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character %h", o_out_char);
                error_count++;
            end else begin
                want = pending_chars.pop_front();
                if (o_out_char !== want.out_char) begin
                    $error("out_char: expected %h, got %h", want.out_char, o_out_char);
                    error_count++;
                end
                if (o_char_valid !== want.char_valid) begin
                    $error("char_valid: expected %b, got %b", want.char_valid, o_char_valid);
                    error_count++;
                end
                if (o_run_last !== want.run_last) begin
                    $error("run_last: expected %b, got %b", want.run_last, o_run_last);
                    error_count++;
                end
                if (o_encoded_end !== want.encoded_end) begin
                    $error("encoded_end: expected %b, got %b", want.encoded_end,
                           o_encoded_end);
                    error_count++;
                end
                if (o_was_stopped !== want.was_stopped) begin
                    $error("was_stopped: expected %b, got %b", want.was_stopped,
                           o_was_stopped);
                    error_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Hold valid across back-to-back requests; drop it only when a gap follows
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_text_end  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        encode_byte(b, last);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic wrap, input logic [9:0] line_len,
                              input logic cap, input logic [15:0] cap_len);
        logic [CFG_INDEX_W-1:0] idx;
        drain_results();
        for (int k = 0; k < 4; k++) begin
            idx = CFG_INDEX_W'(k);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            case (idx)
                REG_LINE_WRAP_ON:  i_cfg_data <= CFG_DATA_W'(wrap);
                REG_MAX_LINE_LEN:  i_cfg_data <= CFG_DATA_W'(line_len);
                REG_LENGTH_CAP_ON: i_cfg_data <= CFG_DATA_W'(cap);
                default:           i_cfg_data <= cap_len;
            endcase
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx)
                REG_LINE_WRAP_ON:  enc_cfg.line_wrap_on  = wrap;
                REG_MAX_LINE_LEN:  enc_cfg.max_line_len  = line_len;
                REG_LENGTH_CAP_ON: enc_cfg.length_cap_on = cap;
                default:           enc_cfg.max_len       = cap_len;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Reset defaults: no wrap, no cap; both sides of each escape boundary
    task automatic test_escapes();
        logic [7:0] bytes[9];
        bytes = '{8'h00, 8'h20, 8'h21, 8'h3C, 8'h3D, 8'h3E, 8'h7E, 8'h7F, 8'hFF};
        foreach (bytes[k]) send_byte(bytes[k], k == 8);
    endtask

    task automatic test_soft_breaks();
        write_regs(1'b1, 10'd9, 1'b0, 16'hFFFF);
        send_byte("a", 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte("b", 1'b0);
        send_byte("c", 1'b1);
        // limit below three: a break after every byte
        write_regs(1'b1, 10'd0, 1'b0, 16'hFFFF);
        send_byte("x", 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    task automatic test_length_cap();
        write_regs(1'b1, 10'd3, 1'b1, 16'd8);
        send_byte("a", 1'b0);
        send_byte(CH_EQ, 1'b0);     // reaches the cap, no break after it
        send_byte("b", 1'b0);
        send_byte("c", 1'b1);
        // cap below three: stop after the very first byte
        write_regs(1'b0, 10'd1023, 1'b1, 16'd1);
        send_byte("x", 1'b0);
        send_byte("!", 1'b1);
    endtask

    task automatic test_random_texts();
        int sent;
        int len;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_regs(1'b0, 10'd76, 1'b0, 16'hFFFF);
                1: write_regs(1'b1, 10'd1023, 1'b1, 16'hFFFF);
                2: write_regs(1'b1, 10'd0, 1'b0, 16'd0);
                3: write_regs(1'b1, 10'($urandom_range(4, 40)), 1'b1,
                              16'($urandom_range(30, 300)));
                4: write_regs(1'b1, 10'd2, 1'b1, 16'd2);
                5: write_regs(1'b0, 10'd1, 1'b1, 16'd3);
                default: write_regs(1'($urandom_range(0, 1)), 10'($urandom_range(3, 90)),
                                    1'($urandom_range(0, 1)), 16'($urandom_range(10, 400)));
            endcase
            no_idle = (phase == 2);
            sent = 0;
            while (sent < 42) begin
                len = $urandom_range(1, 20);
                if (len > 42 - sent) len = 42 - sent;
                for (int k = 0; k < len; k++) begin
                    // in phase 3, hold the sender after ten bytes until the output has caught up
                    if (phase == 3 && sent == 10) drain_results();
                    send_byte(rand_byte(), k == len - 1);
                    sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_LINE_WRAP_ON;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_data_byte    = 8'h00;
        i_text_end     = 1'b0;
        i_out_ready    = 1'b0;
        stall_left     = 0;
        no_idle        = 1'b0;
        error_count    = 0;
        enc_cfg        = '{line_wrap_on: 1'b0, max_line_len: 10'd76, length_cap_on: 1'b0,
                           max_len: 16'hFFFF};
        enc_line_count = '0;
        enc_out_count  = '0;
        enc_stopped    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_escapes();
        test_soft_breaks();
        test_length_cap();
        test_random_texts();

        drain_results();
        repeat (12) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** quoted_printable_encoder_core: PASSED **");
        end else begin
            $display("** quoted_printable_encoder_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("** quoted_printable_encoder_core: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/qpe_pkg.sv
hw/rtl/qpe_front.sv
hw/rtl/qpe_queue.sv
hw/rtl/qpe_back.sv
hw/rtl/quoted_printable_encoder_core.sv
test/quoted_printable_encoder_core_tb.sv
